// ----- rtl/mlp_pkg.sv -----
// mlp_pkg: shared types, constants and tanh table function for mlp_tanh_forward.
// No dependencies.
package mlp_pkg;

	typedef enum logic [1:0] {
		REQ_WEIGHT = 2'd0,
		REQ_BIAS   = 2'd1,
		REQ_SAMPLE = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		CFG_NUM_LAYERS = 3'd0,
		CFG_SIZE0      = 3'd1,
		CFG_SIZE1      = 3'd2,
		CFG_SIZE2      = 3'd3,
		CFG_SIZE3      = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_POST,
		ST_EMIT,
		ST_CLEAR
	} eng_state_t;

	localparam int IDX_W   = 10;
	localparam int VAL_W   = 16;
	localparam int OUT_W   = 14;
	localparam int OIDX_W  = 4;
	localparam int ACC_W   = 40;
	localparam int CFGD_W  = 5;
	localparam int CFGI_W  = 3;

	// queue entry between front and back end
	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             final_sample;
	} req_t;

	// configuration write beat
	typedef struct packed {
		logic [CFGI_W-1:0] index;
		logic [CFGD_W-1:0] value;
	} cfg_t;

	// result beat
	typedef struct packed {
		logic signed [OUT_W-1:0] out_value;
		logic [OIDX_W-1:0]       out_index;
		logic                    out_last;
	} rsp_t;

	// tanh at p, rounded to the nearest Q4.12 value: evaluated at elaboration only
	function automatic logic signed [VAL_W-1:0] tanh_entry(input real p);
		real t;
		int  r;
		begin
			t = $tanh(p);
			r = $rtoi(t * 4096.0 + (t < 0.0 ? -0.5 : 0.5));
			tanh_entry = VAL_W'(r);
		end
	endfunction

endpackage

// ----- rtl/mlp_if.sv -----
// mlp_if: valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface mlp_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mlp_tanh_forward.sv -----
// mlp_tanh_forward: top level, configuration registers, front/back wiring.
// Depends on mlp_pkg, mlp_if, mlp_front, mlp_back.
//
// Loads and samples pass through a four-entry queue. The beat carrying
// final_sample starts a run: per neuron, a bias state, one multiply-accumulate
// step per input of the previous layer, a drain of the multiply pipeline and a
// tanh and write-back state; then one output beat per neuron of the last layer,
// held under back-pressure, and a clear of the activation buffers. Request beats
// wait in the queue during a run; configuration writes are held off until the
// block is idle. The single multiply-accumulate unit and the single weight read
// port set the length of a run.
module mlp_tanh_forward import mlp_pkg::*; #(
	parameter int MAX_WIDTH    = 16,
	parameter int MAX_LAYERS   = 4,
	parameter int WEIGHT_DEPTH = 1024,
	parameter int BIAS_DEPTH   = 64,
	parameter int TANH_TABLE   = 256
) (
	input  logic clk,
	input  logic arst_n,
	mlp_if.sink   req,
	mlp_if.source rsp,
	mlp_if.sink   cfg
);
	req_t       q_req;
	logic       q_valid, q_ready;
	logic [2:0] num_layers_q;
	logic [4:0] size_q [4];
	logic       busy;

	// registers only change while nothing is queued or running
	assign cfg.ready = !busy && !q_valid;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_layers_q <= 3'd3;
			size_q[0] <= 5'd16; size_q[1] <= 5'd16; size_q[2] <= 5'd4; size_q[3] <= 5'd4;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				CFG_NUM_LAYERS: num_layers_q <= cfg.data.value[2:0];
				CFG_SIZE0:      size_q[0] <= cfg.data.value;
				CFG_SIZE1:      size_q[1] <= cfg.data.value;
				CFG_SIZE2:      size_q[2] <= cfg.data.value;
				CFG_SIZE3:      size_q[3] <= cfg.data.value;
				default: ;
			endcase
		end
	end

	mlp_front u_front (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .in_req(req.data),
		.q_valid, .q_ready, .q_req
	);

	mlp_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_LAYERS(MAX_LAYERS), .WEIGHT_DEPTH(WEIGHT_DEPTH),
		.BIAS_DEPTH(BIAS_DEPTH), .TANH_TABLE(TANH_TABLE)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.num_layers(num_layers_q), .size_l(size_q),
		.o_valid(rsp.valid), .o_ready(rsp.ready),
		.o_value(rsp.data.out_value), .o_index(rsp.data.out_index),
		.o_last(rsp.data.out_last), .busy
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data.out_index))
		else $error("result beat dropped while stalled");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.out_value <= 14'sd4096 && rsp.data.out_value >= -14'sd4096)
		else $error("tanh output out of range");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !q_ready)
		else $error("queue drained during emission");
endmodule

// ----- rtl/mlp_front.sv -----
// mlp_front: accepts request beats, classifies them, queues them for the back end.
// Depends on mlp_pkg.
module mlp_front import mlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       in_req,
	output logic       q_valid,
	input  logic       q_ready,
	output req_t       q_req
);
	localparam int QD = 4;
	req_t       mem_q [QD];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       push, pop, keep;

	// type 3 beats are dropped at the door
	assign keep     = in_req.req_type != REQ_NONE;
	assign in_ready = cnt_q != 3'(QD);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = cnt_q != 3'd0;
	assign pop      = q_valid && q_ready;
	assign q_req    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

// ----- rtl/mlp_back.sv -----
// mlp_back: weight/bias memories, activation buffers and the MAC sequencer.
// Depends on mlp_pkg.
module mlp_back import mlp_pkg::*; #(
	parameter int MAX_WIDTH    = 16,
	parameter int MAX_LAYERS   = 4,
	parameter int WEIGHT_DEPTH = 1024,
	parameter int BIAS_DEPTH   = 64,
	parameter int TANH_TABLE   = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  req_t                     q_req,
	input  logic [2:0]               num_layers,
	input  logic [4:0]               size_l [4],
	output logic                     o_valid,
	input  logic                     o_ready,
	output logic signed [OUT_W-1:0]  o_value,
	output logic [OIDX_W-1:0]        o_index,
	output logic                     o_last,
	output logic                     busy
);
	localparam int WA = $clog2(WEIGHT_DEPTH);
	localparam int BA = $clog2(BIAS_DEPTH);
	localparam int AA = $clog2(MAX_WIDTH);
	localparam int TA = $clog2(TANH_TABLE);
	localparam int SIZE_CAP  = MAX_WIDTH < 16 ? MAX_WIDTH : 16;
	localparam int LAYER_CAP = MAX_LAYERS < 4 ? MAX_LAYERS : 4;
	localparam real TANH_STEP = 8.0 / TANH_TABLE;

	logic signed [VAL_W-1:0] wmem [WEIGHT_DEPTH];
	logic signed [VAL_W-1:0] bmem [BIAS_DEPTH];
	logic signed [VAL_W-1:0] act_q [2][MAX_WIDTH];
	logic signed [VAL_W-1:0] tanh_rom [TANH_TABLE];

	for (genvar k = 0; k < TANH_TABLE; k++) begin : g_rom
		assign tanh_rom[k] = tanh_entry(-4.0 + TANH_STEP * k);
	end

	eng_state_t state_q, state_d;
	logic [1:0] layer_q;          // layer being computed, 1..
	logic       src_q;            // which buffer holds the previous layer
	logic [4:0] j_q, i_q;
	logic [WA-1:0] row_q, waddr_q;
	logic [BA-1:0] boff_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] wrd_s1, brd_s1, ard_s1;
	logic signed [31:0] prod_s2;
	logic       mv_s1, mv_s2;
	logic [4:0] emit_q;

	logic [2:0] lc;
	logic [4:0] prev_sz, cur_sz;

	function automatic logic [4:0] clamp_sz(input logic [4:0] s);
		if (s == 5'd0) return 5'd1;
		if (s > 5'(SIZE_CAP)) return 5'(SIZE_CAP);
		return s;
	endfunction

	always_comb begin
		lc = num_layers;
		if (lc < 3'd2) lc = 3'd2;
		if (lc > 3'(LAYER_CAP)) lc = 3'(LAYER_CAP);
	end
	assign prev_sz = clamp_sz(size_l[layer_q - 2'd1]);
	assign cur_sz  = clamp_sz(size_l[layer_q]);

	logic is_idle, take;
	assign is_idle = state_q == ST_IDLE;
	assign q_ready = is_idle;
	assign take    = q_valid && q_ready;
	assign busy    = !is_idle || o_valid;

	// load writes
	always_ff @(posedge clk) begin
		if (take && q_req.req_type == REQ_WEIGHT && 32'(q_req.index) < WEIGHT_DEPTH)
			wmem[WA'(q_req.index)] <= q_req.value;
		if (take && q_req.req_type == REQ_BIAS && 32'(q_req.index) < BIAS_DEPTH)
			bmem[BA'(q_req.index)] <= q_req.value;
	end

	// registered memory reads
	always_ff @(posedge clk) begin
		wrd_s1 <= wmem[waddr_q];
		brd_s1 <= bmem[boff_q + BA'(j_q)];
		ard_s1 <= act_q[src_q][AA'(i_q)];
		prod_s2 <= wrd_s1 * ard_s1;
	end

	// saturate then tanh
	logic signed [ACC_W-1:0] shq;
	logic signed [VAL_W-1:0] sat, tv;
	logic [VAL_W:0] u;
	logic [VAL_W+TA:0] kk;
	always_comb begin
		shq = acc_q >>> 12;
		if (shq > 40'sd32767) sat = 16'sh7fff;
		else if (shq < -40'sd32768) sat = 16'sh8000;
		else sat = shq[VAL_W-1:0];
		u  = 17'($signed({sat[15], sat}) + 17'sd16384);
		kk = (((VAL_W+TA+1)'(u) * (VAL_W+TA+1)'(TANH_TABLE)) + (VAL_W+TA+1)'(16384)) >> 15;
		if (kk > (VAL_W+TA+1)'(TANH_TABLE-1)) kk = (VAL_W+TA+1)'(TANH_TABLE-1);
		if (sat < -16'sd16384) tv = -16'sd4096;
		else if (sat > 16'sd16383) tv = 16'sd4096;
		else tv = tanh_rom[TA'(kk)];
	end

	logic last_layer;
	assign last_layer = 3'(layer_q) + 3'd1 == lc;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (take && q_req.req_type == REQ_SAMPLE && q_req.final_sample)
				state_d = ST_BIAS;
			ST_BIAS:  state_d = ST_MAC;
			ST_MAC:   if (i_q + 5'd1 == prev_sz) state_d = ST_DRAIN;
			ST_DRAIN: if (!mv_s1 && !mv_s2) state_d = ST_POST;
			ST_POST:  if (j_q + 5'd1 == cur_sz) state_d = last_layer ? ST_EMIT : ST_BIAS;
				else state_d = ST_BIAS;
			ST_EMIT:  if (o_valid && o_ready && o_last) state_d = ST_CLEAR;
			ST_CLEAR: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int b = 0; b < 2; b++)
				for (int k = 0; k < MAX_WIDTH; k++) act_q[b][k] <= '0;
			layer_q <= 2'd1; src_q <= 1'b0; j_q <= '0; i_q <= '0;
			row_q <= '0; waddr_q <= '0; boff_q <= '0; mv_s1 <= 1'b0; mv_s2 <= 1'b0;
			emit_q <= '0; o_valid <= 1'b0; acc_q <= '0;
		end else begin
			state_q <= state_d;
			mv_s1 <= state_q == ST_MAC;
			mv_s2 <= mv_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (take && q_req.req_type == REQ_SAMPLE && 32'(q_req.index) < MAX_WIDTH)
						act_q[0][AA'(q_req.index)] <= q_req.value;
					layer_q <= 2'd1; src_q <= 1'b0; j_q <= '0; i_q <= '0;
					row_q <= '0; waddr_q <= '0; boff_q <= '0;
				end
				ST_BIAS: begin
					i_q <= '0;
					waddr_q <= row_q;
				end
				ST_MAC: begin
					if (i_q == 5'd0) acc_q <= ACC_W'(brd_s1) <<< 12;
					if (i_q + 5'd1 != prev_sz) begin
						i_q <= i_q + 5'd1;
						waddr_q <= waddr_q + 1'b1;
					end
				end
				ST_DRAIN: ;
				ST_POST: begin
					act_q[!src_q][AA'(j_q)] <= tv;
					row_q <= row_q + WA'(prev_sz);
					if (j_q + 5'd1 == cur_sz) begin
						j_q <= '0;
						boff_q <= boff_q + BA'(cur_sz);
						src_q <= !src_q;
						if (!last_layer) layer_q <= layer_q + 2'd1;
						else begin
							o_valid <= 1'b1;
							emit_q <= '0;
						end
					end else j_q <= j_q + 5'd1;
				end
				ST_EMIT: begin
					if (o_valid && o_ready) begin
						if (o_last) o_valid <= 1'b0;
						else emit_q <= emit_q + 5'd1;
					end
				end
				ST_CLEAR: begin
					for (int b = 0; b < 2; b++)
						for (int k = 0; k < MAX_WIDTH; k++) act_q[b][k] <= '0;
				end
				default: ;
			endcase
			// accumulate two stages behind the address walk; first product waits for bias
			if (mv_s2) acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign o_value = OUT_W'(act_q[src_q][AA'(emit_q)]);
	assign o_index = OIDX_W'(emit_q);
	assign o_last  = emit_q + 5'd1 == cur_sz;
endmodule
